@@ design/tpst_pkg.sv @@
// Package with the shared types and codes of the tile parameter stream tracker.
`timescale 1ns / 1ps

package tpst_pkg;

    // Frame states, as they appear on the result channel.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_V32   = 3'd1;
    localparam logic [2:0] ST_V64   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_H2V32 = 3'd4;
    localparam logic [2:0] ST_H2V64 = 3'd5;
    localparam logic [2:0] ST_V64H  = 3'd6;
    localparam logic [2:0] ST_MODH  = 3'd7;

    // Parameter type codes of the control word.
    localparam logic [2:0] PT_END_LIST = 3'd0;
    localparam logic [2:0] PT_CLIP     = 3'd1;
    localparam logic [2:0] PT_LIST_SET = 3'd2;
    localparam logic [2:0] PT_POLYGON  = 3'd4;
    localparam logic [2:0] PT_SPRITE   = 3'd5;
    localparam logic [2:0] PT_VERTEX   = 3'd7;

    // List codes.
    localparam logic [2:0] LIST_MAX  = 3'd4;
    localparam logic [2:0] LIST_NONE = 3'd7;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    typedef struct packed {
        logic       func;
        logic [2:0] para_type;
        logic [2:0] list_type;
        logic       textured_flag;
        logic       offset_flag;
        logic [1:0] color_type;
        logic       two_volume_flag;
    } item_t;

    typedef struct packed {
        logic [2:0] open_list;
        logic [2:0] frame_state;
    } track_state_t;

    typedef struct packed {
        logic [2:0] frame_state;
        logic       list_end_valid;
        logic [2:0] list_end_type;
        logic       invalid_param;
        logic       list_error;
    } result_t;

    localparam track_state_t STATE_RESET = '{open_list: LIST_NONE, frame_state: ST_IDLE};

endpackage

@@ design/tpst_state_mem.sv @@
// One-entry state memory with a registered read port and a valid bit for the reset value.
`timescale 1ns / 1ps

module tpst_state_mem (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic                   wr_en,
    input  tpst_pkg::track_state_t wr_data,
    output tpst_pkg::track_state_t rd_data
);

    tpst_pkg::track_state_t mem_reg [0:0];
    tpst_pkg::track_state_t rd_data_reg;
    logic                   valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[0] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end
    end

    // An entry never written reads as the reset state.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg ? mem_reg[0] : tpst_pkg::STATE_RESET;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/tpst_next.sv @@
// Next-state and flag logic for one parameter block.
`timescale 1ns / 1ps

module tpst_next (
    input  tpst_pkg::item_t        item,
    input  tpst_pkg::track_state_t cur,
    output tpst_pkg::track_state_t nxt,
    output tpst_pkg::result_t      res
);

    function automatic logic [2:0] header_next(input logic tex, input logic off,
                                               input logic [1:0] col, input logic vol);
        logic h64;
        logic v64;
        if (!vol) begin
            h64 = (col == 2'd2) && tex && off;
            v64 = tex && (col == 2'd1);
        end else begin
            h64 = (col == 2'd1) || (col == 2'd2);
            v64 = tex && (col != 2'd1);
        end
        if (h64) begin
            header_next = v64 ? tpst_pkg::ST_H2V64 : tpst_pkg::ST_H2V32;
        end else begin
            header_next = v64 ? tpst_pkg::ST_V64 : tpst_pkg::ST_V32;
        end
    endfunction

    logic [2:0] list_sel;
    logic [2:0] hdr_state;

    assign list_sel  = (cur.open_list == tpst_pkg::LIST_NONE) ? item.list_type : cur.open_list;
    assign hdr_state = header_next(item.textured_flag, item.offset_flag,
                                   item.color_type, item.two_volume_flag);

    always_comb begin
        nxt                = cur;
        res.list_end_valid = 1'b0;
        res.list_end_type  = 3'd0;
        res.invalid_param  = 1'b0;
        res.list_error     = 1'b0;
        if (item.func) begin
            nxt.frame_state = tpst_pkg::ST_IDLE;
        end else begin
            case (cur.frame_state)
                tpst_pkg::ST_H2V32: begin
                    nxt.frame_state = tpst_pkg::ST_V32;
                end
                tpst_pkg::ST_H2V64, tpst_pkg::ST_V64H: begin
                    nxt.frame_state = tpst_pkg::ST_V64;
                end
                tpst_pkg::ST_MODH: begin
                    nxt.frame_state = tpst_pkg::ST_MOD;
                end
                default: begin
                    case (item.para_type)
                        tpst_pkg::PT_END_LIST: begin
                            if (list_sel <= tpst_pkg::LIST_MAX) begin
                                res.list_end_valid = 1'b1;
                                res.list_end_type  = list_sel;
                            end else begin
                                res.list_error = 1'b1;
                            end
                            nxt.open_list   = tpst_pkg::LIST_NONE;
                            nxt.frame_state = tpst_pkg::ST_IDLE;
                        end
                        tpst_pkg::PT_CLIP, tpst_pkg::PT_LIST_SET: begin
                            nxt.frame_state = cur.frame_state;
                        end
                        tpst_pkg::PT_POLYGON: begin
                            if (cur.frame_state == tpst_pkg::ST_IDLE) begin
                                nxt.open_list = list_sel;
                                // Odd list codes are modifier lists.
                                nxt.frame_state = list_sel[0] ? tpst_pkg::ST_MOD : hdr_state;
                            end else if (cur.frame_state == tpst_pkg::ST_MOD) begin
                                nxt.frame_state = tpst_pkg::ST_MOD;
                            end else begin
                                nxt.frame_state = hdr_state;
                            end
                        end
                        tpst_pkg::PT_SPRITE: begin
                            if (cur.frame_state == tpst_pkg::ST_MOD) begin
                                res.invalid_param = 1'b1;
                            end else begin
                                if (cur.frame_state == tpst_pkg::ST_IDLE) begin
                                    nxt.open_list  = list_sel;
                                    res.list_error = list_sel[0];
                                end
                                nxt.frame_state = tpst_pkg::ST_V64;
                            end
                        end
                        tpst_pkg::PT_VERTEX: begin
                            case (cur.frame_state)
                                tpst_pkg::ST_V32: nxt.frame_state = tpst_pkg::ST_V32;
                                tpst_pkg::ST_V64: nxt.frame_state = tpst_pkg::ST_V64H;
                                tpst_pkg::ST_MOD: nxt.frame_state = tpst_pkg::ST_MODH;
                                default:          res.invalid_param = 1'b1;
                            endcase
                        end
                        default: begin
                            res.invalid_param = 1'b1;
                        end
                    endcase
                end
            endcase
        end
        res.frame_state = nxt.frame_state;
    end

endmodule

@@ design/tile_param_stream_tracker.sv @@
// Top level of the tile parameter stream tracker: read stage, update stage and result register.
//
//   Channel | Direction | Ports                        | Contents
//   s_      | in        | s_tvalid s_tready s_tdata    | one 32-byte block or control transfer
//           |           | s_tuser                      |
//   m_      | out       | m_tvalid m_tready m_tdata    | one result per input transfer
//
// One transfer is accepted per cycle while m_ does not stall; each passes the update stage, then the result register.
// The rate is set by the read-modify-write of the state memory, with the
// value written in the same cycle as a read forwarded to the following block.
// Reset is synchronous; the state then reads as idle with no list open.
// A stall on m_ holds the result register and an occupied update stage, and s_tready then falls.
`timescale 1ns / 1ps

module tile_param_stream_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] para_type, [5:3] list_type, [6] textured_flag, [7] offset_flag,
    // [9:8] color_type, [10] two_volume_flag, [15:11] zero
    input  logic [tpst_pkg::TDATA_IN_W-1:0]  s_tdata,
    // [0] func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] frame_state, [3] list_end_valid, [6:4] list_end_type, [7] invalid_param,
    // [8] list_error, [15:9] zero
    output logic [tpst_pkg::TDATA_OUT_W-1:0] m_tdata
);

    tpst_pkg::item_t        in_item;
    tpst_pkg::item_t        s1_item_reg;
    logic                   s1_vld_reg;
    logic                   out_vld_reg;
    tpst_pkg::result_t      out_res_reg;
    tpst_pkg::result_t      upd_res;
    tpst_pkg::track_state_t mem_rd;
    tpst_pkg::track_state_t cur_state;
    tpst_pkg::track_state_t upd_state;
    tpst_pkg::track_state_t fwd_data_reg;
    logic                   fwd_reg;
    logic                   advance;
    logic                   in_accept;
    logic                   wr_en;

    assign in_item = '{func:            s_tuser,
                       para_type:       s_tdata[2:0],
                       list_type:       s_tdata[5:3],
                       textured_flag:   s_tdata[6],
                       offset_flag:     s_tdata[7],
                       color_type:      s_tdata[9:8],
                       two_volume_flag: s_tdata[10]};

    assign advance   = !out_vld_reg || m_tready;
    assign s_tready  = !s1_vld_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign wr_en     = s1_vld_reg && advance;

    tpst_state_mem u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .wr_en   (wr_en),
        .wr_data (upd_state),
        .rd_data (mem_rd)
    );

    // A write in the same cycle as the read is not yet in the read data, so it is kept aside.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fwd_reg      <= wr_en;
            fwd_data_reg <= upd_state;
        end
    end

    assign cur_state = fwd_reg ? fwd_data_reg : mem_rd;

    tpst_next u_next (
        .item (s1_item_reg),
        .cur  (cur_state),
        .nxt  (upd_state),
        .res  (upd_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg <= in_item;
        end
        if (wr_en) begin
            out_res_reg <= upd_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.list_error,
                       out_res_reg.invalid_param,
                       out_res_reg.list_end_type,
                       out_res_reg.list_end_valid,
                       out_res_reg.frame_state};

endmodule
